>>> rtl/core/color_key_sprite_blitter_assert.svh
// Assertion macros used by the verification checker of the sprite blitter.
`ifndef COLOR_KEY_SPRITE_BLITTER_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CKB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CKB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ckb_pkg.sv
// Types and constants shared by the sprite blitter modules.
`timescale 1ns / 1ps

package ckb_pkg;

   localparam int WORD_W    = 16;
   localparam int FB_ADDR_W = 17;
   localparam int POS_W     = 11;
   localparam int CSR_IDX_W = 3;
   // Screen coordinate before clipping: 11-bit signed origin plus two 16-bit terms.
   localparam int SX_W      = 19;

   localparam logic [WORD_W-1:0] KEY_RESET = 16'h4FE0;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POS_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_X0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_Y0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_X1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_Y1    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR = 3'd7;

   typedef enum logic [2:0] {
      PH_WIDTH  = 3'd0,
      PH_HEIGHT = 3'd1,
      PH_OFF_X  = 3'd2,
      PH_OFF_Y  = 3'd3,
      PH_PIXELS = 3'd4
   } ckb_phase_type;

   // Stream position and sprite header as seen by the pixel datapath.
   typedef struct packed {
      logic              pixel;
      logic [WORD_W-1:0] width;
      logic [WORD_W-1:0] height;
      logic [WORD_W-1:0] off_x;
      logic [WORD_W-1:0] off_y;
      logic [WORD_W-1:0] col;
      logic [WORD_W-1:0] row;
   } ckb_pos_type;

endpackage

>>> rtl/core/ckb_if.sv
// Valid/ready channel interfaces of the sprite blitter.
`timescale 1ns / 1ps

interface ckb_req_if import ckb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface ckb_rsp_if import ckb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FB_ADDR_W-1:0] fb_address;
   logic [WORD_W-1:0]    color;

   modport source (output valid, output fb_address, output color, input ready);
   modport sink   (input valid, input fb_address, input color, output ready);
endinterface

interface ckb_csr_if import ckb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/ckb_seq.sv
// Sprite stream sequencer: header capture and pixel column/row counters.
`timescale 1ns / 1ps

module ckb_seq import ckb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic [WORD_W-1:0] word,
   output ckb_pos_type       pos
);

   ckb_phase_type     phase_ff, phase_in;
   logic [WORD_W-1:0] width_ff, width_in;
   logic [WORD_W-1:0] height_ff, height_in;
   logic [WORD_W-1:0] off_x_ff, off_x_in;
   logic [WORD_W-1:0] off_y_ff, off_y_in;
   logic [WORD_W-1:0] col_ff, col_in;
   logic [WORD_W-1:0] row_ff, row_in;

   logic              row_end;
   logic [WORD_W-1:0] row_step;
   logic              sprite_end;
   logic              empty_sprite;

   // Compared in one extra bit so that a full-width column count cannot wrap.
   assign row_end      = ({1'b0, col_ff} + (WORD_W+1)'(1)) >= {1'b0, width_ff};
   assign row_step     = row_ff + WORD_W'(1);
   assign sprite_end   = row_end && (row_step >= height_ff);
   assign empty_sprite = (width_ff == '0) || (height_ff == '0);

   always_comb begin
      phase_in = phase_ff;
      if (beat) begin
         case (phase_ff)
            PH_WIDTH:  phase_in = PH_HEIGHT;
            PH_HEIGHT: phase_in = PH_OFF_X;
            PH_OFF_X:  phase_in = PH_OFF_Y;
            PH_OFF_Y:  phase_in = empty_sprite ? PH_WIDTH : PH_PIXELS;
            PH_PIXELS: phase_in = sprite_end ? PH_WIDTH : PH_PIXELS;
            default:   phase_in = PH_WIDTH;
         endcase
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (beat) begin
         case (phase_ff)
            PH_WIDTH:  width_in  = word;
            PH_HEIGHT: height_in = word;
            PH_OFF_X:  off_x_in  = word;
            PH_OFF_Y: begin
               off_y_in = word;
               col_in   = '0;
               row_in   = '0;
            end
            PH_PIXELS: begin
               if (row_end) begin
                  col_in = '0;
                  row_in = sprite_end ? '0 : row_step;
               end else begin
                  col_in = col_ff + WORD_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      pos.pixel  = (phase_ff == PH_PIXELS);
      pos.width  = width_ff;
      pos.height = height_ff;
      pos.off_x  = off_x_ff;
      pos.off_y  = off_y_ff;
      pos.col    = col_ff;
      pos.row    = row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WIDTH;
         width_ff  <= '0;
         height_ff <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> rtl/core/color_key_sprite_blitter.sv
// Top level of the color-key sprite blitter.
`timescale 1ns / 1ps

// The sprite arrives on req_bus as 16-bit beats: width, height, x offset and
// y offset, then width*height RGB565 pixels in row-major order. Every pixel
// that lies inside the configured window, differs from the key color and lands
// on the screen leaves as one beat on rsp_bus carrying the frame-buffer index
// (row * SCREEN_WIDTH + column) and the color. Header beats and dropped pixels
// produce nothing.
// Configuration registers are written through csr_bus, which is always ready;
// write them only while no sprite pixels are in flight.
// Throughput is one beat per cycle while the receiver does not stall. A drawn
// pixel is registered in the middle stage after the window, key and clipping
// checks, then in the output register with the constant multiply-add address.
// When the receiver stalls, the output register holds its beat and the middle
// stage keeps one more; req_bus.ready drops only once both are full, and
// nothing is lost or repeated.
// Synchronous reset returns the stream parser to expecting a width header,
// empties the pipeline and resets every configuration register.

module color_key_sprite_blitter import ckb_pkg::*; #(
   parameter int SCREEN_WIDTH  = 396,
   parameter int SCREEN_HEIGHT = 224
) (
   input  logic      clock,
   input  logic      reset,
   ckb_req_if.sink   req_bus,
   ckb_rsp_if.source rsp_bus,
   ckb_csr_if.sink   csr_bus
);

   localparam int COL_W  = $clog2(SCREEN_WIDTH);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int SW_W   = $clog2(SCREEN_WIDTH + 1);
   localparam int SUM_W  = ROW_W + SW_W + 1;
   localparam int CALC_W = (SUM_W > FB_ADDR_W) ? SUM_W : FB_ADDR_W;

   // Configuration registers.
   logic [POS_W-1:0]  pos_x_ff, pos_y_ff;
   logic [WORD_W-1:0] win_x0_ff, win_y0_ff, win_x1_ff, win_y1_ff;
   logic              mirror_ff;
   logic [WORD_W-1:0] key_color_ff;

   // Pipeline registers.
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [WORD_W-1:0] s1_color_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FB_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [WORD_W-1:0]    rsp_color_ff;

   ckb_pos_type       pos;
   logic              req_beat;
   logic              out_free;
   logic              s1_free;
   logic [WORD_W-1:0] dcol, xend, yend;
   logic              in_window;
   logic [SX_W-1:0]   sx, sy;
   logic              on_screen;
   logic              draw;
   logic [CALC_W-1:0] addr_full;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         win_x0_ff    <= '0;
         win_y0_ff    <= '0;
         win_x1_ff    <= '1;
         win_y1_ff    <= '1;
         mirror_ff    <= 1'b0;
         key_color_ff <= KEY_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_POS_X:     pos_x_ff     <= csr_bus.data[POS_W-1:0];
            CSR_POS_Y:     pos_y_ff     <= csr_bus.data[POS_W-1:0];
            CSR_WIN_X0:    win_x0_ff    <= csr_bus.data;
            CSR_WIN_Y0:    win_y0_ff    <= csr_bus.data;
            CSR_WIN_X1:    win_x1_ff    <= csr_bus.data;
            CSR_WIN_Y1:    win_y1_ff    <= csr_bus.data;
            CSR_MIRROR:    mirror_ff    <= csr_bus.data[0];
            CSR_KEY_COLOR: key_color_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Handshake: the middle stage may take a beat when it is empty or drains
   // into the output register in the same cycle.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_free       = !s1_valid_ff || out_free;
   assign req_bus.ready = !reset && s1_free;
   assign req_beat      = req_bus.valid && req_bus.ready;

   ckb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .beat  (req_beat),
      .word  (req_bus.pixel_word),
      .pos   (pos)
   );

   // Window and key test. In mirror mode the drawn column counts from the
   // right edge of the sprite.
   assign dcol = mirror_ff ? (pos.width - WORD_W'(1) - pos.col) : pos.col;
   assign xend = (win_x1_ff < pos.width)  ? win_x1_ff : pos.width;
   assign yend = (win_y1_ff < pos.height) ? win_y1_ff : pos.height;
   assign in_window = (dcol >= win_x0_ff) && (dcol < xend) &&
                      (pos.row >= win_y0_ff) && (pos.row < yend);

   // Screen position: signed origin plus unsigned offset and sprite position.
   assign sx = {{(SX_W-POS_W){pos_x_ff[POS_W-1]}}, pos_x_ff} +
               SX_W'(pos.off_x) + SX_W'(dcol);
   assign sy = {{(SX_W-POS_W){pos_y_ff[POS_W-1]}}, pos_y_ff} +
               SX_W'(pos.off_y) + SX_W'(pos.row);
   assign on_screen = !sx[SX_W-1] && (sx < SX_W'(SCREEN_WIDTH)) &&
                      !sy[SX_W-1] && (sy < SX_W'(SCREEN_HEIGHT));

   assign draw = pos.pixel && in_window && on_screen &&
                 (req_bus.pixel_word != key_color_ff);

   assign s1_valid_in = (s1_valid_ff && !out_free) || (req_beat && draw);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_col_ff   <= sx[COL_W-1:0];
         s1_row_ff   <= sy[ROW_W-1:0];
         s1_color_ff <= req_bus.pixel_word;
      end
   end

   // Frame-buffer index: a multiply by the screen width constant and one add.
   assign addr_full = CALC_W'(s1_row_ff) * CALC_W'(SCREEN_WIDTH) + CALC_W'(s1_col_ff);
   assign rsp_addr_in  = addr_full[FB_ADDR_W-1:0];
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_color_ff <= s1_color_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.fb_address = rsp_addr_ff;
   assign rsp_bus.color      = rsp_color_ff;

endmodule

>>> rtl/core/ckb_checker.sv
// Port-level assertion checker for the sprite blitter and its bind.
`timescale 1ns / 1ps
`include "color_key_sprite_blitter_assert.svh"

module ckb_checker import ckb_pkg::*; #(
   parameter int SCREEN_WIDTH  = 396,
   parameter int SCREEN_HEIGHT = 224
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [FB_ADDR_W-1:0] rsp_fb_address,
   input logic [WORD_W-1:0]    rsp_color,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   localparam longint AREA      = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
   localparam bit     AREA_FITS = AREA <= (longint'(1) << FB_ADDR_W);
   localparam logic [FB_ADDR_W:0] AREA_LIM = (FB_ADDR_W+1)'(AREA);

   `CKB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_fb_address) && $stable(rsp_color),
      "stalled response beat changed or vanished")

   `CKB_ASSERT_IMPL(a_addr_range, clock, reset, rsp_valid,
      !AREA_FITS || ({1'b0, rsp_fb_address} < AREA_LIM),
      "frame buffer index beyond the screen")

   `CKB_ASSERT_IMPL(a_rsp_latency, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready, 2),
      "response appeared without a request beat two cycles earlier")

   `CKB_ASSERT_IMPL(a_csr_ready, clock, reset, csr_valid, csr_ready,
      "configuration write was not taken")

endmodule

bind color_key_sprite_blitter ckb_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ckb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_fb_address (rsp_bus.fb_address),
   .rsp_color      (rsp_bus.color),
   .csr_valid      (csr_bus.valid),
   .csr_ready      (csr_bus.ready)
);
